// File: hdl/ptxq_pkg.sv
package ptxq_pkg;

  // Default geometry of the queue.
  localparam int QUEUE_SLOTS_DEF      = 8;
  localparam int MAX_PACKET_BYTES_DEF = 256;

  // Operation codes of a request.
  localparam logic [1:0] OP_PUSH     = 2'd0;
  localparam logic [1:0] OP_COMPLETE = 2'd1;
  localparam logic [1:0] OP_SERVICE  = 2'd2;
  localparam logic [1:0] OP_READ     = 2'd3;

  // Transmitter answers to a start.
  localparam logic [1:0] RSP_STARTED = 2'd0;
  localparam logic [1:0] RSP_BUSY    = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the request fields
    logic exec;     // apply the request to the queue state
    logic fetch;    // read length and byte memories at the head
    logic load;     // load the response register
  } ptxq_cmd_t;

endpackage

// File: hdl/ptxq_ram.sv
module ptxq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/ptxq_ctrl.sv
module ptxq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ptxq_pkg::ptxq_cmd_t cmd
);
  import ptxq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FETCH, S_DONE} state_t;

  state_t state;
  logic   out_free;

  // The response register can take a new value when empty or being drained.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  // Commands follow the state directly.
  always_comb begin
    cmd.capture = (state == S_IDLE) && req_valid;
    cmd.exec    = (state == S_EXEC);
    cmd.fetch   = (state == S_FETCH);
    cmd.load    = (state == S_DONE) && out_free;
  end

  // Sequencer and response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC:  state <= S_FETCH;
        S_FETCH: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/ptxq_datapath.sv
module ptxq_datapath #(
  parameter int QUEUE_SLOTS      = ptxq_pkg::QUEUE_SLOTS_DEF,
  parameter int MAX_PACKET_BYTES = ptxq_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ptxq_pkg::ptxq_cmd_t cmd,
  input  logic [1:0]          operation,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [1:0]          start_response,
  input  logic [7:0]          read_offset,
  output logic                accepted,
  output logic                start_issued,
  output logic [2:0]          head_slot,
  output logic [8:0]          head_length,
  output logic [7:0]          read_data,
  output logic [3:0]          queue_count,
  output logic                tx_active,
  output logic [31:0]         dropped_count,
  output logic [31:0]         enqueued_count,
  output logic [31:0]         completed_count,
  output logic [31:0]         busy_retry_count,
  output logic [31:0]         start_error_count
);
  import ptxq_pkg::*;

  localparam int SW    = $clog2(QUEUE_SLOTS);
  localparam int CW    = $clog2(QUEUE_SLOTS + 1);
  localparam int LW    = $clog2(MAX_PACKET_BYTES + 1);
  localparam int DEPTH = QUEUE_SLOTS * MAX_PACKET_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = (LW > 8) ? LW : 8;

  // Captured request fields.
  logic [1:0] op_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic [1:0] resp_q;
  logic [7:0] offs_q;

  // Queue state.
  logic [SW-1:0] head, tail;
  logic [CW-1:0] count;
  logic [LW-1:0] wo;
  logic          too_long, busy, done;
  logic [31:0]   cnt_drop, cnt_enq, cnt_done, cnt_busy, cnt_err;
  logic          acc, started;

  logic [SW-1:0] head_next, tail_next;
  logic [CW-1:0] count_next;
  logic [LW-1:0] wo_next, wo_v;
  logic          too_long_next, tl_v, busy_next, done_next, busy_v;
  logic          drop_inc, enq_inc, done_inc, busy_inc, err_inc;
  logic          acc_next, started_next;
  logic          byte_we, len_we;

  logic [LW-1:0] len_rdata, hl;
  logic [7:0]    byte_rdata;
  logic [AW-1:0] byte_waddr, byte_raddr;
  logic          has_pkt;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    next_slot = (s == SW'(QUEUE_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= operation;
      byte_q <= data_byte;
      last_q <= last_byte;
      resp_q <= start_response;
      offs_q <= read_offset;
    end
  end

  // Next queue state for the captured request.
  always_comb begin
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    wo_next       = wo;
    too_long_next = too_long;
    busy_next     = busy;
    done_next     = done;
    wo_v          = wo;
    tl_v          = too_long;
    busy_v        = busy;
    drop_inc      = 1'b0;
    enq_inc       = 1'b0;
    done_inc      = 1'b0;
    busy_inc      = 1'b0;
    err_inc       = 1'b0;
    acc_next      = 1'b0;
    started_next  = 1'b0;
    byte_we       = 1'b0;
    len_we        = 1'b0;
    case (op_q)
      OP_PUSH: begin
        // Bytes past the slot size are dropped and mark the packet too long.
        if (wo < LW'(MAX_PACKET_BYTES)) begin
          byte_we = cmd.exec && (count < CW'(QUEUE_SLOTS));
          wo_v    = wo + 1'b1;
        end else begin
          tl_v = 1'b1;
        end
        if (last_q) begin
          if (!tl_v) begin
            if (count >= CW'(QUEUE_SLOTS)) begin
              drop_inc = 1'b1;
            end else begin
              len_we     = cmd.exec;
              tail_next  = next_slot(tail);
              count_next = count + 1'b1;
              enq_inc    = 1'b1;
              acc_next   = 1'b1;
            end
          end
          wo_next       = '0;
          too_long_next = 1'b0;
        end else begin
          wo_next       = wo_v;
          too_long_next = tl_v;
        end
      end
      OP_COMPLETE: begin
        if (busy) begin
          done_next = 1'b1;
        end
      end
      OP_SERVICE: begin
        // Retire a finished head first.
        if (busy && done) begin
          done_next = 1'b0;
          busy_v    = 1'b0;
          if (count != '0) begin
            head_next  = next_slot(head);
            count_next = count - 1'b1;
            done_inc   = 1'b1;
          end
        end
        busy_next = busy_v;
        // Then start the head when idle and not empty.
        if (!busy_v && count_next != '0) begin
          done_next    = 1'b0;
          started_next = 1'b1;
          case (resp_q)
            RSP_STARTED: busy_next = 1'b1;
            RSP_BUSY:    busy_inc  = 1'b1;
            default:     err_inc   = 1'b1;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // State update.
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      wo       <= '0;
      too_long <= 1'b0;
      busy     <= 1'b0;
      done     <= 1'b0;
      cnt_drop <= '0;
      cnt_enq  <= '0;
      cnt_done <= '0;
      cnt_busy <= '0;
      cnt_err  <= '0;
    end else if (cmd.exec) begin
      head     <= head_next;
      tail     <= tail_next;
      count    <= count_next;
      wo       <= wo_next;
      too_long <= too_long_next;
      busy     <= busy_next;
      done     <= done_next;
      cnt_drop <= cnt_drop + 32'(drop_inc);
      cnt_enq  <= cnt_enq + 32'(enq_inc);
      cnt_done <= cnt_done + 32'(done_inc);
      cnt_busy <= cnt_busy + 32'(busy_inc);
      cnt_err  <= cnt_err + 32'(err_inc);
    end
  end

  // Flags of the item, held until the response is loaded.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc     <= acc_next;
      started <= started_next;
    end
  end

  // Packet byte store, addressed by slot and offset.
  assign byte_waddr = AW'(tail) * AW'(MAX_PACKET_BYTES) + AW'(wo);
  assign byte_raddr = AW'(head) * AW'(MAX_PACKET_BYTES) + AW'(offs_q);

  ptxq_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_bytes (
    .clk  (clk),
    .we   (byte_we),
    .waddr(byte_waddr),
    .wdata(byte_q),
    .re   (cmd.fetch),
    .raddr(byte_raddr),
    .rdata(byte_rdata)
  );

  // Packet lengths, one per slot.
  ptxq_ram #(
    .WIDTH(LW),
    .DEPTH(QUEUE_SLOTS)
  ) u_lengths (
    .clk  (clk),
    .we   (len_we),
    .waddr(tail),
    .wdata(wo_v),
    .re   (cmd.fetch),
    .raddr(head),
    .rdata(len_rdata)
  );

  assign has_pkt = (count != '0);
  assign hl      = has_pkt ? len_rdata : '0;

  // Response register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      accepted          <= acc;
      start_issued      <= started;
      head_slot         <= 3'(head);
      head_length       <= 9'(hl);
      queue_count       <= 4'(count);
      tx_active         <= busy;
      dropped_count     <= cnt_drop;
      enqueued_count    <= cnt_enq;
      completed_count   <= cnt_done;
      busy_retry_count  <= cnt_busy;
      start_error_count <= cnt_err;
      if (op_q == OP_READ && has_pkt && XW'(offs_q) < XW'(hl)
          && XW'(offs_q) < XW'(MAX_PACKET_BYTES)) begin
        read_data <= byte_rdata;
      end else begin
        read_data <= '0;
      end
    end
  end

endmodule

// File: hdl/packet_tx_queue_top.sv
// Transmit packet queue: a ring of QUEUE_SLOTS slots, each of MAX_PACKET_BYTES
// bytes, fed one byte per request and committed on the byte marked last.
// Every request (push, transmit complete, service, read) yields one response
// carrying the head slot, its length, the packet count, the in-flight flag and
// five wrapping 32-bit counters. A request goes through capture, state update,
// a registered read of the slot length and byte memories at the head, and
// loading of the response register. The next request is taken while a finished
// response still waits in its register. Slot bytes and lengths hold no reset
// value; only positions that have been written are meaningful.
module packet_tx_queue_top #(
  parameter int QUEUE_SLOTS      = ptxq_pkg::QUEUE_SLOTS_DEF,
  parameter int MAX_PACKET_BYTES = ptxq_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [1:0]  start_response,
  input  logic [7:0]  read_offset,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        accepted,
  output logic        start_issued,
  output logic [2:0]  head_slot,
  output logic [8:0]  head_length,
  output logic [7:0]  read_data,
  output logic [3:0]  queue_count,
  output logic        tx_active,
  output logic [31:0] dropped_count,
  output logic [31:0] enqueued_count,
  output logic [31:0] completed_count,
  output logic [31:0] busy_retry_count,
  output logic [31:0] start_error_count
);
  import ptxq_pkg::*;

  ptxq_cmd_t cmd;

  // Request sequencing.
  ptxq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .cmd      (cmd)
  );

  // Queue state, memories and response register.
  ptxq_datapath #(
    .QUEUE_SLOTS     (QUEUE_SLOTS),
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .operation        (operation),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .start_response   (start_response),
    .read_offset      (read_offset),
    .accepted         (accepted),
    .start_issued     (start_issued),
    .head_slot        (head_slot),
    .head_length      (head_length),
    .read_data        (read_data),
    .queue_count      (queue_count),
    .tx_active        (tx_active),
    .dropped_count    (dropped_count),
    .enqueued_count   (enqueued_count),
    .completed_count  (completed_count),
    .busy_retry_count (busy_retry_count),
    .start_error_count(start_error_count)
  );

`ifndef ASSERT_OFF
  // Only one step of the sequence is active in any cycle.
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.exec, cmd.fetch, cmd.load}))
    else $error("more than one sequencer command active");

  // A captured request stalls the next one until its work is done.
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while the previous one is in progress");

  // The state update always follows a capture.
  a_exec_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> $past(cmd.capture))
    else $error("state update without a captured request");

  // Loading the response register presents a response.
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> rsp_valid)
    else $error("response loaded but not presented");
`endif

endmodule
